// File: sv/pkvbm_pkg.sv
// Shared constants, codes and types of the paged KV block manager.
package pkvbm_pkg;

    // Sizes of the managed resources
    localparam int NUM_BLOCKS_DEF = 256;
    localparam int NUM_SEQS_DEF   = 64;
    localparam int MAX_BPS_DEF    = 32;

    // Widths derived from the sizes
    localparam int BLK_W = $clog2(NUM_BLOCKS_DEF);
    localparam int SEQ_W = $clog2(NUM_SEQS_DEF);
    localparam int IDX_W = $clog2(MAX_BPS_DEF);
    localparam int LEN_W = $clog2(MAX_BPS_DEF + 1);
    localparam int TOP_W = $clog2(NUM_BLOCKS_DEF + 1);
    localparam int TOK_W = 7;
    localparam int ST_W  = 3;
    localparam int KIND_W = 2;

    localparam logic [TOK_W-1:0] TPB_RESET = 7'd16;

    // Operation codes
    localparam logic [KIND_W-1:0] K_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] K_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] K_FREE   = 2'd2;
    localparam logic [KIND_W-1:0] K_FORK   = 2'd3;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_EXISTS   = 3'd1;
    localparam logic [ST_W-1:0] ST_NOMEM    = 3'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

    // One entry of the per-block table
    typedef struct packed {
        logic [TOK_W-1:0] tok;
        logic [TOK_W-1:0] refs;
    } t_blk_ent;

    // Write request to the per-block table
    typedef struct packed {
        logic             en;
        logic [BLK_W-1:0] addr;
        t_blk_ent         ent;
    } t_blk_wr;

endpackage

// File: sv/pkvbm_blk_table.sv
// Per-block token and reference count table with reset-to-zero valid bits.
module pkvbm_blk_table import pkvbm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [BLK_W-1:0] i_rd_addr,
    output t_blk_ent         o_rd_data,
    input  t_blk_wr          i_wr
);

    t_blk_ent                  r_mem [NUM_BLOCKS_DEF];
    logic [NUM_BLOCKS_DEF-1:0] r_vld;
    t_blk_ent                  r_rd;

    // An entry never written reads as zero counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.ent;
        end
        r_rd <= r_vld[i_rd_addr] ? r_mem[i_rd_addr] : '0;
    end

    assign o_rd_data = r_rd;

endmodule

// File: sv/paged_kv_block_manager_top.sv
// Top level of the paged KV block manager: sequencer, free stack and block lists.
//
// Usage: one operation word enters on the input channel (i_in_valid, o_in_stall)
// with kind, seq_id and child slot; exactly one result word leaves on the
// output channel (o_out_valid, i_out_stall). A word moves at a rising edge with
// valid high and stall low. tokens_per_block is written through i_cfg_we and
// i_cfg_data while the block is idle.
// Free and fork walk the sequence's block list entry by entry, each entry
// going through a list read state and then a block table read state. The walk
// is set by the single read port of the list and block table memories. After
// each result the sequencer returns to idle before the next word is accepted,
// so a new word is taken only once the last result has left.
// Reset: all blocks are free with the stack holding block i at entry i, all
// counts are zero, no sequence is active and tokens_per_block is 16. Reset
// takes effect at once through valid bits; no clearing pass is needed.
// When the receiver stalls, the result word is held unchanged and no new
// operation is accepted.
module paged_kv_block_manager_top import pkvbm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [TOK_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_kind,
    input  logic [5:0]       i_seq_id,
    input  logic [5:0]       i_child_slot,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [2:0]       o_status,
    output logic [7:0]       o_blk_num,
    output logic             o_took_block,
    output logic [8:0]       o_free_count,
    output logic [5:0]       o_seq_blocks
);

    localparam int LST_AW = SEQ_W + IDX_W;

    typedef enum logic [3:0] {
        S_IDLE, S_LEN, S_FIN_A, S_FIN_B, S_ALLOC, S_APP_LB, S_APP_TB, S_APP_POP,
        S_FR_LST, S_FR_TB, S_FK_LST, S_FK_TB, S_OUT
    } t_state;

    t_state                r_state, n_state;
    logic [KIND_W-1:0]     r_kind, n_kind;
    logic [SEQ_W-1:0]      r_s, n_s, r_c, n_c, r_shown, n_shown;
    logic [LEN_W-1:0]      r_len, n_len;
    logic [IDX_W-1:0]      r_i, n_i;
    logic [BLK_W-1:0]      r_b, n_b, r_blk, n_blk;
    logic [ST_W-1:0]       r_status, n_status;
    logic                  r_took, n_took;
    logic [LEN_W-1:0]      r_seqb, n_seqb;
    logic [TOP_W-1:0]      r_top, n_top;
    logic [TOK_W-1:0]      r_tpb, n_tpb;
    logic [NUM_SEQS_DEF-1:0] r_act, n_act;

    // Memory ports
    logic [BLK_W-1:0]  lst_mem [1 << LST_AW];
    logic [LEN_W-1:0]  len_mem [NUM_SEQS_DEF];
    logic [BLK_W-1:0]  stk_mem [NUM_BLOCKS_DEF];
    logic [NUM_BLOCKS_DEF-1:0] r_stk_vld;
    logic [BLK_W-1:0]  r_lst_rd, r_stk_rd;
    logic [LEN_W-1:0]  r_len_rd;

    logic              lst_we, len_we, stk_we;
    logic [LST_AW-1:0] lst_wa, lst_ra;
    logic [BLK_W-1:0]  lst_wd, stk_wa, stk_wd, stk_ra;
    logic [SEQ_W-1:0]  len_wa, len_ra;
    logic [LEN_W-1:0]  len_wd;
    logic [BLK_W-1:0]  tbl_ra;
    t_blk_wr           tbl_wr;
    t_blk_ent          tbl_rd;

    // Helpers of the sequencer
    logic              act_s;
    logic [LEN_W-1:0]  len_s, len_f, len_m1, i_p1;
    logic              walk_last;

    pkvbm_blk_table u_tbl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (tbl_ra),
        .o_rd_data (tbl_rd),
        .i_wr      (tbl_wr)
    );

    // Block list memory, one row of entries per sequence slot.
    always_ff @(posedge i_clk) begin
        if (lst_we) begin
            lst_mem[lst_wa] <= lst_wd;
        end
        r_lst_rd <= lst_mem[lst_ra];
    end

    // List lengths; the value read is used only for active slots.
    always_ff @(posedge i_clk) begin
        if (len_we) begin
            len_mem[len_wa] <= len_wd;
        end
        r_len_rd <= len_mem[len_ra];
    end

    // Free stack; an entry never written holds its own index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stk_vld <= '0;
        end else if (stk_we) begin
            r_stk_vld[stk_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_wa] <= stk_wd;
        end
        r_stk_rd <= r_stk_vld[stk_ra] ? stk_mem[stk_ra] : stk_ra;
    end

    assign act_s     = r_act[r_s];
    assign len_s     = act_s ? r_len_rd : '0;
    assign len_f     = r_act[r_shown] ? r_len_rd : '0;
    assign len_m1    = len_f - LEN_W'(1);
    assign i_p1      = LEN_W'(r_i) + LEN_W'(1);
    assign walk_last = (i_p1 >= r_len);

    // Sequencer next state and memory accesses.
    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_s      = r_s;
        n_c      = r_c;
        n_shown  = r_shown;
        n_len    = r_len;
        n_i      = r_i;
        n_b      = r_b;
        n_blk    = r_blk;
        n_status = r_status;
        n_took   = r_took;
        n_seqb   = r_seqb;
        n_top    = r_top;
        n_act    = r_act;
        n_tpb    = i_cfg_we ? i_cfg_data : r_tpb;
        lst_we   = 1'b0;
        lst_wa   = '0;
        lst_wd   = '0;
        lst_ra   = '0;
        len_we   = 1'b0;
        len_wa   = '0;
        len_wd   = '0;
        len_ra   = '0;
        stk_we   = 1'b0;
        stk_wa   = '0;
        stk_wd   = '0;
        stk_ra   = '0;
        tbl_ra   = '0;
        tbl_wr   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = i_kind;
                    n_s     = i_seq_id[SEQ_W-1:0];
                    n_c     = i_child_slot[SEQ_W-1:0];
                    len_ra  = i_seq_id[SEQ_W-1:0];
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                n_len    = len_s;
                n_took   = 1'b0;
                n_status = ST_OK;
                n_shown  = r_s;
                n_i      = '0;
                case (r_kind)
                    K_ALLOC: begin
                        if (act_s || (r_top == '0)) begin
                            n_status = act_s ? ST_EXISTS : ST_NOMEM;
                            len_ra   = r_s;
                            n_state  = S_FIN_A;
                        end else begin
                            stk_ra  = BLK_W'(r_top - TOP_W'(1));
                            n_top   = r_top - TOP_W'(1);
                            n_state = S_ALLOC;
                        end
                    end
                    K_APPEND: begin
                        if (!act_s) begin
                            n_status = ST_NOTFOUND;
                            n_blk    = '0;
                            n_seqb   = '0;
                            n_state  = S_OUT;
                        end else begin
                            lst_ra  = {r_s, IDX_W'(len_s - LEN_W'(1))};
                            n_state = S_APP_LB;
                        end
                    end
                    K_FREE: begin
                        if (!act_s || (len_s == '0)) begin
                            n_act[r_s] = 1'b0;
                            n_blk      = '0;
                            n_seqb     = '0;
                            n_state    = S_OUT;
                        end else begin
                            lst_ra  = {r_s, IDX_W'(0)};
                            n_state = S_FR_LST;
                        end
                    end
                    default: begin
                        n_shown = r_c;
                        if (!act_s || r_act[r_c]) begin
                            n_status = act_s ? ST_EXISTS : ST_NOTFOUND;
                            len_ra   = r_c;
                            n_state  = S_FIN_A;
                        end else if (len_s == '0) begin
                            len_we     = 1'b1;
                            len_wa     = r_c;
                            len_wd     = '0;
                            n_act[r_c] = 1'b1;
                            n_blk      = '0;
                            n_seqb     = '0;
                            n_state    = S_OUT;
                        end else begin
                            lst_ra  = {r_s, IDX_W'(0)};
                            n_state = S_FK_LST;
                        end
                    end
                endcase
            end
            // Report the last block and length of the slot shown.
            S_FIN_A: begin
                n_seqb = len_f;
                if (len_f == '0) begin
                    n_blk   = '0;
                    n_state = S_OUT;
                end else begin
                    lst_ra  = {r_shown, IDX_W'(len_m1)};
                    n_state = S_FIN_B;
                end
            end
            S_FIN_B: begin
                n_blk   = r_lst_rd;
                n_state = S_OUT;
            end
            S_ALLOC: begin
                tbl_wr.en       = 1'b1;
                tbl_wr.addr     = r_stk_rd;
                tbl_wr.ent.tok  = '0;
                tbl_wr.ent.refs = TOK_W'(1);
                lst_we          = 1'b1;
                lst_wa          = {r_s, IDX_W'(0)};
                lst_wd          = r_stk_rd;
                len_we          = 1'b1;
                len_wa          = r_s;
                len_wd          = LEN_W'(1);
                n_act[r_s]      = 1'b1;
                n_took          = 1'b1;
                n_blk           = r_stk_rd;
                n_seqb          = LEN_W'(1);
                n_state         = S_OUT;
            end
            S_APP_LB: begin
                n_b     = r_lst_rd;
                tbl_ra  = r_lst_rd;
                n_state = S_APP_TB;
            end
            S_APP_TB: begin
                n_blk  = r_b;
                n_seqb = r_len;
                if (tbl_rd.tok < r_tpb) begin
                    tbl_wr.en       = 1'b1;
                    tbl_wr.addr     = r_b;
                    tbl_wr.ent.tok  = tbl_rd.tok + TOK_W'(1);
                    tbl_wr.ent.refs = tbl_rd.refs;
                    n_state         = S_OUT;
                end else if (r_len >= LEN_W'(MAX_BPS_DEF)) begin
                    n_status = ST_FULL;
                    n_state  = S_OUT;
                end else if (r_top == '0) begin
                    n_status = ST_NOMEM;
                    n_state  = S_OUT;
                end else begin
                    stk_ra  = BLK_W'(r_top - TOP_W'(1));
                    n_top   = r_top - TOP_W'(1);
                    n_state = S_APP_POP;
                end
            end
            S_APP_POP: begin
                tbl_wr.en       = 1'b1;
                tbl_wr.addr     = r_stk_rd;
                tbl_wr.ent.tok  = TOK_W'(1);
                tbl_wr.ent.refs = TOK_W'(1);
                lst_we          = 1'b1;
                lst_wa          = {r_s, IDX_W'(r_len)};
                lst_wd          = r_stk_rd;
                len_we          = 1'b1;
                len_wa          = r_s;
                len_wd          = r_len + LEN_W'(1);
                n_took          = 1'b1;
                n_blk           = r_stk_rd;
                n_seqb          = r_len + LEN_W'(1);
                n_state         = S_OUT;
            end
            // Free walk: drop one reference per listed block, freeing unused ones.
            S_FR_LST: begin
                n_b     = r_lst_rd;
                tbl_ra  = r_lst_rd;
                n_state = S_FR_TB;
            end
            S_FR_TB: begin
                if (tbl_rd.refs != '0) begin
                    tbl_wr.en       = 1'b1;
                    tbl_wr.addr     = r_b;
                    tbl_wr.ent.refs = tbl_rd.refs - TOK_W'(1);
                    tbl_wr.ent.tok  = tbl_rd.tok;
                    if (tbl_rd.refs == TOK_W'(1)) begin
                        tbl_wr.ent.tok = '0;
                        if (r_top < TOP_W'(NUM_BLOCKS_DEF)) begin
                            stk_we = 1'b1;
                            stk_wa = BLK_W'(r_top);
                            stk_wd = r_b;
                            n_top  = r_top + TOP_W'(1);
                        end
                    end
                end
                if (!walk_last) begin
                    n_i     = r_i + IDX_W'(1);
                    lst_ra  = {r_s, IDX_W'(i_p1)};
                    n_state = S_FR_LST;
                end else begin
                    n_act[r_s] = 1'b0;
                    n_blk      = '0;
                    n_seqb     = '0;
                    n_state    = S_OUT;
                end
            end
            // Fork walk: copy each entry to the child and add a reference.
            S_FK_LST: begin
                n_b     = r_lst_rd;
                lst_we  = 1'b1;
                lst_wa  = {r_c, r_i};
                lst_wd  = r_lst_rd;
                tbl_ra  = r_lst_rd;
                n_state = S_FK_TB;
            end
            S_FK_TB: begin
                tbl_wr.en       = 1'b1;
                tbl_wr.addr     = r_b;
                tbl_wr.ent.tok  = tbl_rd.tok;
                tbl_wr.ent.refs = tbl_rd.refs + TOK_W'(1);
                if (!walk_last) begin
                    n_i     = r_i + IDX_W'(1);
                    lst_ra  = {r_s, IDX_W'(i_p1)};
                    n_state = S_FK_LST;
                end else begin
                    len_we     = 1'b1;
                    len_wa     = r_c;
                    len_wd     = r_len;
                    n_act[r_c] = 1'b1;
                    n_blk      = r_b;
                    n_seqb     = r_len;
                    n_state    = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= TOP_W'(NUM_BLOCKS_DEF);
            r_tpb   <= TPB_RESET;
            r_act   <= '0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_tpb   <= n_tpb;
            r_act   <= n_act;
        end
        r_kind   <= n_kind;
        r_s      <= n_s;
        r_c      <= n_c;
        r_shown  <= n_shown;
        r_len    <= n_len;
        r_i      <= n_i;
        r_b      <= n_b;
        r_blk    <= n_blk;
        r_status <= n_status;
        r_took   <= n_took;
        r_seqb   <= n_seqb;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_status     = r_status;
    assign o_blk_num    = 8'(r_blk);
    assign o_took_block = r_took;
    assign o_free_count = 9'(r_top);
    assign o_seq_blocks = 6'(r_seqb);

    // The free stack never holds more than every block.
    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= TOP_W'(NUM_BLOCKS_DEF))
        else $error("free stack pointer beyond block count");

    // A block leaves the stack only on a successful operation.
    a_took_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_took_block) |-> (o_status == ST_OK))
        else $error("block taken on a failed operation");

    // An accepted word closes the input channel until its result is out.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && !o_out_valid))
        else $error("input channel open right after accept");

    // A taken block leaves the free count below the block count.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_took_block && $rose(o_out_valid))
            |-> (o_free_count < 9'(NUM_BLOCKS_DEF)))
        else $error("free count not lowered by a taken block");

endmodule

// File: dv/tb.sv
// Testbench for the paged KV block manager: scoreboard with predictor, drivers and checks.
`timescale 1ns / 1ps

module tb import pkvbm_pkg::*; ();

    localparam int NBLK = NUM_BLOCKS_DEF;
    localparam int NSEQ = NUM_SEQS_DEF;
    localparam int MAXB = MAX_BPS_DEF;

    // One result word as the block reports it
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] blk_num;
        logic       took;
        logic [8:0] free_count;
        logic [5:0] seq_blocks;
    } t_result;

    int err_count = 0;

    // Prints one mismatch line and counts it.
    task automatic report_err(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Scoreboard: mirrors the allocator state and queues the expected result words.
    class kv_scoreboard;
        logic [6:0] tpb;
        logic [7:0] stack_mem [NBLK];
        int         top;
        logic [6:0] tokens [NBLK];
        logic [6:0] refs [NBLK];
        bit         active [NSEQ];
        logic [7:0] blist [NSEQ][MAXB];
        int         len [NSEQ];
        t_result    pending [$];

        function void clear();
            for (int i = 0; i < NBLK; i++) begin
                stack_mem[i] = i[7:0];
                tokens[i] = '0;
                refs[i] = '0;
            end
            top = NBLK;
            for (int i = 0; i < NSEQ; i++) begin
                active[i] = 0;
                len[i] = 0;
            end
            tpb = TPB_RESET;
            pending.delete();
        endfunction

        function logic [7:0] tail_block(int s);
            if (!active[s] || len[s] == 0) return 8'd0;
            return blist[s][len[s]-1];
        endfunction

        function logic [7:0] take_block();
            top--;
            return stack_mem[top];
        endfunction

        // Applies one accepted operation word and queues its result.
        function void note_op(logic [1:0] kind, logic [5:0] sid, logic [5:0] cid);
            int s, c, shown, b;
            t_result r;
            s = sid;
            c = cid;
            shown = s;
            r = '0;
            r.status = ST_OK;
            case (kind)
                K_ALLOC: begin
                    if (active[s]) r.status = ST_EXISTS;
                    else if (top == 0) r.status = ST_NOMEM;
                    else begin
                        b = take_block();
                        refs[b] = 7'd1;
                        tokens[b] = 7'd0;
                        blist[s][0] = 8'(b);
                        len[s] = 1;
                        active[s] = 1;
                        r.took = 1'b1;
                        r.blk_num = 8'(b);
                    end
                end
                K_APPEND: begin
                    if (!active[s]) r.status = ST_NOTFOUND;
                    else begin
                        b = tail_block(s);
                        if (tokens[b] < tpb) tokens[b]++;
                        else if (len[s] >= MAXB) r.status = ST_FULL;
                        else if (top == 0) r.status = ST_NOMEM;
                        else begin
                            b = take_block();
                            refs[b] = 7'd1;
                            tokens[b] = 7'd1;
                            blist[s][len[s]] = 8'(b);
                            len[s]++;
                            r.took = 1'b1;
                            r.blk_num = 8'(b);
                        end
                    end
                end
                K_FREE: begin
                    if (active[s]) begin
                        for (int i = 0; i < len[s]; i++) begin
                            b = blist[s][i];
                            if (refs[b] != 0) begin
                                refs[b]--;
                                if (refs[b] == 0) begin
                                    tokens[b] = 7'd0;
                                    if (top < NBLK) begin
                                        stack_mem[top] = 8'(b);
                                        top++;
                                    end
                                end
                            end
                        end
                        active[s] = 0;
                        len[s] = 0;
                    end
                end
                default: begin
                    shown = c;
                    if (!active[s]) r.status = ST_NOTFOUND;
                    else if (active[c]) r.status = ST_EXISTS;
                    else begin
                        for (int i = 0; i < len[s]; i++) begin
                            b = blist[s][i];
                            refs[b]++;
                            blist[c][i] = 8'(b);
                        end
                        len[c] = len[s];
                        active[c] = 1;
                    end
                end
            endcase
            if (!r.took) r.blk_num = tail_block(shown);
            r.free_count = 9'(top);
            r.seq_blocks = active[shown] ? 6'(len[shown]) : 6'd0;
            pending = {pending, r};
        endfunction

        // Compares one result word with the oldest expectation.
        task check_result(t_result got);
            t_result exp_r;
            if (pending.size() == 0) begin
                report_err("result word with nothing expected");
                return;
            end
            exp_r = pending.pop_front();
            if (got.status !== exp_r.status)
                report_err($sformatf("status %0d, expected %0d", got.status, exp_r.status));
            if (got.blk_num !== exp_r.blk_num)
                report_err($sformatf("blk_num %0d, expected %0d",
                                     got.blk_num, exp_r.blk_num));
            if (got.took !== exp_r.took)
                report_err($sformatf("took_block %0b, expected %0b", got.took, exp_r.took));
            if (got.free_count !== exp_r.free_count)
                report_err($sformatf("free_count %0d, expected %0d",
                                     got.free_count, exp_r.free_count));
            if (got.seq_blocks !== exp_r.seq_blocks)
                report_err($sformatf("seq_blocks %0d, expected %0d",
                                     got.seq_blocks, exp_r.seq_blocks));
        endtask
    endclass

    logic             clk = 0;
    logic             rst_n = 0;
    logic             cfg_we = 0;
    logic [TOK_W-1:0] cfg_data = '0;
    logic             in_valid = 0;
    logic             in_stall;
    logic [1:0]       kind = '0;
    logic [5:0]       seq_id = '0;
    logic [5:0]       child_id = '0;
    logic             out_valid;
    logic             out_stall = 0;
    logic [2:0]       status;
    logic [7:0]       blk_num;
    logic             took_block;
    logic [8:0]       free_count;
    logic [5:0]       seq_blocks;

    kv_scoreboard sb;
    bit  quiet_phase = 0;
    bit  long_hold = 0;

    always #2 clk = ~clk;

    paged_kv_block_manager_top u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_kind(kind), .i_seq_id(seq_id), .i_child_slot(child_id),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(status), .o_blk_num(blk_num), .o_took_block(took_block),
        .o_free_count(free_count), .o_seq_blocks(seq_blocks)
    );

    // Offers one operation word, with an optional random gap first, and waits for accept.
    task automatic send_op(input logic [1:0] k, input logic [5:0] s, input logic [5:0] c);
        if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1;
        kind     <= k;
        seq_id   <= s;
        child_id <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_op(k, s, c);
    endtask

    task automatic end_ops();
        in_valid <= 0;
        @(posedge clk);
    endtask

    // Waits until every expected word has come back, then lets the block settle.
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_tpb(input logic [6:0] v);
        cfg_we   <= 1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
        sb.tpb = v;
        @(posedge clk);
    endtask

    // Random slot, biased toward a small pool so that sequences grow and share.
    function automatic logic [5:0] pick_slot();
        if ($urandom_range(0, 9) < 8) return 6'($urandom_range(0, 11));
        return 6'($urandom_range(0, 63));
    endfunction

    // Random operation mix: mostly appends so that lists fill up.
    task automatic random_ops(input int count);
        int r;
        logic [1:0] k;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 20) k = K_ALLOC;
            else if (r < 75) k = K_APPEND;
            else if (r < 88) k = K_FREE;
            else k = K_FORK;
            send_op(k, pick_slot(), pick_slot());
        end
        end_ops();
    endtask

    // Receiver side: samples result words and stalls in random bursts.
    initial begin
        int gap;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result('{status, blk_num, took_block, free_count, seq_blocks});
            if (long_hold) begin
                out_stall <= 1;
            end else if (!quiet_phase && gap == 0 && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 17);
                out_stall <= 1;
            end else if (gap > 0) begin
                gap--;
                out_stall <= (gap != 0);
            end else begin
                out_stall <= 0;
            end
        end
    end

    // Run limit.
    initial begin
        #8ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main sequence.
    initial begin
        sb = new();
        sb.clear();
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: every operation and the not-found and exists cases at reset width.
        send_op(K_APPEND, 6'd5, 6'd0);      // not found
        send_op(K_FORK, 6'd5, 6'd6);        // parent not found
        send_op(K_FREE, 6'd5, 6'd0);        // free of an inactive slot
        send_op(K_ALLOC, 6'd0, 6'd0);
        send_op(K_ALLOC, 6'd0, 6'd0);       // already exists
        send_op(K_ALLOC, 6'd63, 6'd63);
        send_op(K_FORK, 6'd0, 6'd0);        // fork onto itself
        send_op(K_FORK, 6'd0, 6'd63);       // child active
        send_op(K_FORK, 6'd0, 6'd42);
        for (int i = 0; i < 18; i++) send_op(K_APPEND, 6'd0, 6'd0);
        send_op(K_FREE, 6'd42, 6'd0);
        send_op(K_FREE, 6'd0, 6'd0);
        send_op(K_FREE, 6'd63, 6'd0);
        end_ops();
        drain();

        // Zero tokens per block: every append takes a block until the list fills.
        write_tpb(7'd0);
        send_op(K_ALLOC, 6'd1, 6'd0);
        for (int i = 0; i < 33; i++) send_op(K_APPEND, 6'd1, 6'd0);
        send_op(K_FORK, 6'd1, 6'd2);
        send_op(K_FREE, 6'd1, 6'd0);
        send_op(K_FREE, 6'd2, 6'd0);
        end_ops();
        drain();

        // One token per block: exhaust the free stack over many slots.
        write_tpb(7'd1);
        for (int s = 0; s < 9; s++) begin
            send_op(K_ALLOC, s[5:0], 6'd0);
            for (int i = 0; i < 64; i++) send_op(K_APPEND, s[5:0], 6'd0);
        end
        send_op(K_ALLOC, 6'd20, 6'd0);      // out of blocks
        for (int s = 0; s < 9; s++) send_op(K_FREE, s[5:0], 6'd0);
        end_ops();
        drain();

        write_tpb(7'd3);
        random_ops(300);
        drain();

        // Long receiver hold while words keep coming, so the block backs up.
        write_tpb(7'd127);
        fork
            random_ops(40);
            begin
                long_hold = 1;
                repeat (300) @(posedge clk);
                long_hold = 0;
            end
        join
        drain();

        write_tpb(7'd64);
        random_ops(250);
        drain();
        write_tpb(7'd2);
        random_ops(200);
        drain();

        quiet_phase = 1;
        write_tpb(7'd5);
        random_ops(200);
        drain();

        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Leftover expectations after the final drain cannot occur; the drain waits on them.
endmodule
